// ----- sv/rypp_pkg.sv -----
// Shared types, constants and trig table builder for the y-rotation projector.
`timescale 1ns / 1ps
`default_nettype none
package rypp_pkg;

  localparam int TRIG_ENTRIES_DEF = 128;
  localparam int QUO_BITS         = 24;   // |120*rel| < 2**24
  localparam int PROJ_SCALE       = 120;
  localparam int CENTER_X         = 80;
  localparam int CENTER_Y         = 40;
  localparam longint STEP_SIN_Q30 = 64'sd107195315;
  localparam longint STEP_COS_Q30 = 64'sd1068377587;

  typedef enum logic [1:0] {
    REG_CAM_X = 2'd0,
    REG_CAM_Y = 2'd1,
    REG_CAM_Z = 2'd2,
    REG_ANGLE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_z;
    logic signed [6:0]  angle;
  } cfg_t;

  // one item in flight through the divider row
  typedef struct packed {
    logic [QUO_BITS-1:0] nq_x;   // numerator bits shifting out, quotient shifting in
    logic [QUO_BITS-1:0] nq_y;
    logic [16:0]         rem_x;
    logic [16:0]         rem_y;
    logic [16:0]         dvs;
    logic                neg_x;
    logic                neg_y;
    logic signed [17:0]  depth;
    logic                vis;
  } div_t;

  // divide by 2**sh, rounding half away from zero
  function automatic longint round_shr(longint v, int sh);
    longint half, mag;
    half = 64'sd1 <<< (sh - 1);
    mag  = (v < 0) ? -v : v;
    mag  = (mag + half) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  // elaboration-time table entry: Q2.30 rotation recurrence from the center
  function automatic logic signed [15:0] trig_q14(int idx, bit want_cos, int entries);
    longint s, c, ns, nc, ss, one;
    int     h, steps;
    h     = entries >> 1;
    one   = 64'sd1 << 30;
    s     = 0;
    c     = one;
    ss    = (idx >= h) ? STEP_SIN_Q30 : -STEP_SIN_Q30;
    steps = (idx >= h) ? idx - h : h - idx;
    for (int k = 0; k < steps; k++) begin
      ns = round_shr(s * STEP_COS_Q30 + c * ss, 30);
      nc = round_shr(c * STEP_COS_Q30 - s * ss, 30);
      s  = ns;
      c  = nc;
    end
    return want_cos ? 16'(round_shr(c, 16)) : 16'(round_shr(s, 16));
  endfunction

endpackage
`default_nettype wire

// ----- sv/rypp_front.sv -----
// Front pipeline: offsets, rotation products, depth, scaled numerators, divider setup.
`timescale 1ns / 1ps
`default_nettype none
module rypp_front #(
  parameter int TRIG_ENTRIES = rypp_pkg::TRIG_ENTRIES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rypp_pkg::cfg_t       cfg,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire signed [15:0]    pt_x,
  input  wire signed [15:0]    pt_y,
  input  wire signed [15:0]    pt_z,
  output logic                 o_valid,
  input  wire                  o_ready,
  output rypp_pkg::div_t       o_data
);
  import rypp_pkg::*;

  localparam int IDXW = $clog2(TRIG_ENTRIES);
  localparam int H    = TRIG_ENTRIES / 2;
  localparam logic [IDXW:0] HV = (IDXW+1)'(H);

  logic signed [15:0] sin_tbl [TRIG_ENTRIES];
  logic signed [15:0] cos_tbl [TRIG_ENTRIES];

  for (genvar g = 0; g < TRIG_ENTRIES; g++) begin : g_tbl
    localparam logic signed [15:0] SV_ = trig_q14(g, 1'b0, TRIG_ENTRIES);
    localparam logic signed [15:0] CV_ = trig_q14(g, 1'b1, TRIG_ENTRIES);
    assign sin_tbl[g] = SV_;
    assign cos_tbl[g] = CV_;
  end

  // angle fold: remainder toward zero by H, then offset to table center
  logic [7:0]      ang_mag;
  logic [IDXW:0]   ang_rem;
  logic [IDXW:0]   idx_full;
  logic [IDXW-1:0] idx;
  always_comb begin
    ang_mag = cfg.angle[6] ? 8'(-{cfg.angle[6], cfg.angle}) : {1'b0, cfg.angle};
    ang_rem = (IDXW+1)'(ang_mag);
    if (ang_rem >= HV) ang_rem = ang_rem - HV;
    if (ang_rem >= HV) ang_rem = ang_rem - HV;
    idx_full = cfg.angle[6] ? HV - ang_rem : HV + ang_rem;
    idx      = idx_full[IDXW-1:0];
  end

  logic signed [15:0] sin_r, cos_r;
  always_ff @(posedge clk) begin
    sin_r <= sin_tbl[idx];
    cos_r <= cos_tbl[idx];
  end

  logic [5:1] v_r;
  logic [6:1] rdy;
  always_comb begin
    rdy[6] = o_ready;
    for (int k = 5; k >= 1; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign in_ready = rdy[1];
  assign o_valid  = v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 5; k++) if (rdy[k]) v_r[k] <= v_r[k-1];
    end
  end

  // stage 1: offsets
  logic signed [16:0] dx_r, dz_r;
  logic signed [17:0] yr1_r;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dx_r  <= {pt_x[15], pt_x} - {cfg.cam_x[15], cfg.cam_x};
      dz_r  <= {pt_z[15], pt_z} - {cfg.cam_z[15], cfg.cam_z};
      yr1_r <= {{2{pt_y[15]}}, pt_y} - {cfg.cam_y[15], cfg.cam_y, 1'b0};
    end
  end

  // stage 2: rotation products
  logic signed [32:0] pxc_r, pzs_r, pzc_r, pxs_r;
  logic signed [17:0] yr2_r;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pxc_r <= dx_r * cos_r;
      pzs_r <= dz_r * sin_r;
      pzc_r <= dz_r * cos_r;
      pxs_r <= dx_r * sin_r;
      yr2_r <= yr1_r;
    end
  end

  // stage 3: sums, divide by 2**14 toward zero
  logic signed [33:0] sum_x, sum_d, adj_x, adj_d;
  always_comb begin
    sum_x = {pxc_r[32], pxc_r} + {pzs_r[32], pzs_r};
    sum_d = {pzc_r[32], pzc_r} - {pxs_r[32], pxs_r};
    adj_x = sum_x[33] ? (sum_x + 34'sd16383) >>> 14 : sum_x >>> 14;
    adj_d = sum_d[33] ? (sum_d + 34'sd16383) >>> 14 : sum_d >>> 14;
  end

  logic signed [17:0] xr_r, dep3_r, yr3_r;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      xr_r   <= adj_x[17:0];
      dep3_r <= adj_d[17:0];
      yr3_r  <= yr2_r;
    end
  end

  // stage 4: scaled numerators
  logic signed [24:0] nx_r, ny_r;
  logic signed [17:0] dep4_r;
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      nx_r   <= $signed({{7{xr_r[17]}}, xr_r}) * 25'(PROJ_SCALE);
      ny_r   <= $signed({{7{yr3_r[17]}}, yr3_r}) * 25'(PROJ_SCALE);
      dep4_r <= dep3_r;
    end
  end

  // stage 5: magnitudes and divisor for the cell row
  logic [24:0] mag_x, mag_y;
  logic        vis;
  assign mag_x = nx_r[24] ? 25'(-nx_r) : 25'(nx_r);
  assign mag_y = ny_r[24] ? 25'(-ny_r) : 25'(ny_r);
  assign vis   = !dep4_r[17] && (dep4_r != '0);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      o_data.nq_x  <= mag_x[QUO_BITS-1:0];
      o_data.nq_y  <= mag_y[QUO_BITS-1:0];
      o_data.rem_x <= '0;
      o_data.rem_y <= '0;
      o_data.dvs   <= vis ? dep4_r[16:0] : 17'd1;
      o_data.neg_x <= nx_r[24];
      o_data.neg_y <= ny_r[24];
      o_data.depth <= dep4_r;
      o_data.vis   <= vis;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rypp_div_cell.sv -----
// One restoring-division cell: one quotient bit for both x and y per beat.
`timescale 1ns / 1ps
`default_nettype none
module rypp_div_cell (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  rypp_pkg::div_t  in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output rypp_pkg::div_t  out_data
);
  import rypp_pkg::*;

  logic   v_r;
  div_t   d_nxt;
  logic [17:0] tx, ty, dv;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;

  always_comb begin
    d_nxt = in_data;
    dv    = {1'b0, in_data.dvs};
    tx    = {in_data.rem_x, in_data.nq_x[QUO_BITS-1]};
    ty    = {in_data.rem_y, in_data.nq_y[QUO_BITS-1]};
    if (tx >= dv) begin
      d_nxt.rem_x = 17'(tx - dv);
      d_nxt.nq_x  = {in_data.nq_x[QUO_BITS-2:0], 1'b1};
    end else begin
      d_nxt.rem_x = tx[16:0];
      d_nxt.nq_x  = {in_data.nq_x[QUO_BITS-2:0], 1'b0};
    end
    if (ty >= dv) begin
      d_nxt.rem_y = 17'(ty - dv);
      d_nxt.nq_y  = {in_data.nq_y[QUO_BITS-2:0], 1'b1};
    end else begin
      d_nxt.rem_y = ty[16:0];
      d_nxt.nq_y  = {in_data.nq_y[QUO_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_data <= d_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/rotate_y_perspective_project.sv -----
// Top level: config registers, front pipeline, divider cell row, output register.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: pt_x, pt_y, pt_z
//  out_    | out | out_tvalid/out_tready| out_tdata: scr_x, scr_y, view_depth; out_tuser: visible
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// One point per cycle sustained while out_tready stays high; the path is 5 front stages,
// 24 divider cells and 1 output register, the cells forming a one-bit-per-cell quotient row.
// rst_n (sync, active low) clears all valid bits and loads the register defaults.
// Each stage holds its beat only while the one after it is full and stalled, so bubbles
// close up and input is taken while a result waits at the output.
`timescale 1ns / 1ps
`default_nettype none
module rotate_y_perspective_project #(
  parameter int TRIG_ENTRIES = rypp_pkg::TRIG_ENTRIES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,    // pt_x[15:0], pt_y[31:16], pt_z[47:32]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,   // scr_x[15:0], scr_y[31:16], view_depth[49:32], zero pad
  output logic [0:0]  out_tuser,   // visible[0]
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_wdata
);
  import rypp_pkg::*;

  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x <= 16'sd60;
      cfg_r.cam_y <= 16'sd20;
      cfg_r.cam_z <= -16'sd100;
      cfg_r.angle <= 7'sd0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CAM_X: cfg_r.cam_x <= cfg_wdata;
        REG_CAM_Y: cfg_r.cam_y <= cfg_wdata;
        REG_CAM_Z: cfg_r.cam_z <= cfg_wdata;
        REG_ANGLE: cfg_r.angle <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  logic valid_c [QUO_BITS+1];
  logic ready_c [QUO_BITS+1];
  div_t data_c  [QUO_BITS+1];

  rypp_front #(.TRIG_ENTRIES(TRIG_ENTRIES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .pt_x     (in_tdata[15:0]),
    .pt_y     (in_tdata[31:16]),
    .pt_z     (in_tdata[47:32]),
    .o_valid  (valid_c[0]),
    .o_ready  (ready_c[0]),
    .o_data   (data_c[0])
  );

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_cell
    rypp_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_c[g]),
      .in_ready  (ready_c[g]),
      .in_data   (data_c[g]),
      .out_valid (valid_c[g+1]),
      .out_ready (ready_c[g+1]),
      .out_data  (data_c[g+1])
    );
  end

  function automatic logic signed [15:0] sat16(logic signed [25:0] v);
    if (v > 26'sd32767)  return 16'sh7fff;
    if (v < -26'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  div_t               last;
  logic signed [24:0] qx, qy;
  logic signed [25:0] sx, sy;
  logic               out_en;

  assign last   = data_c[QUO_BITS];
  assign out_en = !out_tvalid || out_tready;
  assign ready_c[QUO_BITS] = out_en;

  always_comb begin
    qx = last.neg_x ? -$signed({1'b0, last.nq_x}) : $signed({1'b0, last.nq_x});
    qy = last.neg_y ? -$signed({1'b0, last.nq_y}) : $signed({1'b0, last.nq_y});
    sx = {qx[24], qx} + 26'(CENTER_X);
    sy = {qy[24], qy} + 26'(CENTER_Y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (out_en) out_tvalid <= valid_c[QUO_BITS];
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_tdata[15:0]  <= last.vis ? sat16(sx) : 16'sd0;
      out_tdata[31:16] <= last.vis ? sat16(sy) : 16'sd0;
      out_tdata[49:32] <= last.depth;
      out_tdata[55:50] <= '0;
      out_tuser[0]     <= last.vis;
    end
  end

endmodule
`default_nettype wire
